FILE: src/jses_pkg.sv
// ----------------------------------------------------------------------------
// jses_pkg
// Types, character codes and classification helpers shared by the JSON
// string escaper with UTF-8 validation.
// ----------------------------------------------------------------------------
`default_nettype none

package jses_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RAW_MAX     = 6;

    localparam logic [7:0] BYTE_QUOTE  = 8'h22;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_DEL    = 8'h7F;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] HEX_ALPHA   = 8'h57;
    localparam logic [7:0] REPL_0      = 8'hEF;
    localparam logic [7:0] REPL_1      = 8'hBF;
    localparam logic [7:0] REPL_2      = 8'hBD;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } t_out;

    typedef struct packed {
        logic [2:0]                fffd_cnt;
        logic [2:0]                raw_cnt;
        logic [RAW_MAX-1:0][7:0]   raw;
        logic                      end_flag;
    } t_cmd;

    typedef struct packed {
        logic                      hold;
        logic [2:0]                seq_len;
        logic                      fffd;
        logic [2:0]                raw_cnt;
        logic [RAW_MAX-1:0][7:0]   raw;
    } t_fresh;

    function automatic logic [7:0] f_hex(input logic [3:0] d);
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'h0, d};
        end
        return HEX_ALPHA + {4'h0, d};
    endfunction

    function automatic logic [2:0] f_lead_len(input logic [7:0] b);
        if (b inside {[8'hC2:8'hDF]}) begin
            return 3'd2;
        end else if (b inside {[8'hE0:8'hEF]}) begin
            return 3'd3;
        end else if (b inside {[8'hF0:8'hF4]}) begin
            return 3'd4;
        end
        return 3'd0;
    endfunction

    function automatic logic f_second_ok(input logic [7:0] lead, input logic [7:0] b);
        case (lead)
            LEAD_E0: return b inside {[8'hA0:8'hBF]};
            LEAD_ED: return b inside {[8'h80:8'h9F]};
            LEAD_F0: return b inside {[8'h90:8'hBF]};
            LEAD_F4: return b inside {[8'h80:8'h8F]};
            default: return b inside {[8'h80:8'hBF]};
        endcase
    endfunction

    function automatic t_fresh f_fresh(input logic [7:0] b, input logic last);
        t_fresh     f;
        logic [2:0] len;
        f   = '0;
        len = f_lead_len(b);
        if (b == BYTE_QUOTE || b == BYTE_BSLASH) begin
            f.raw_cnt = 3'd2;
            f.raw[0]  = BYTE_BSLASH;
            f.raw[1]  = b;
        end else if (b == BYTE_LF) begin
            f.raw_cnt = 3'd2;
            f.raw[0]  = BYTE_BSLASH;
            f.raw[1]  = CHAR_N;
        end else if (b == BYTE_CR) begin
            f.raw_cnt = 3'd2;
            f.raw[0]  = BYTE_BSLASH;
            f.raw[1]  = CHAR_R;
        end else if (b == BYTE_TAB) begin
            f.raw_cnt = 3'd2;
            f.raw[0]  = BYTE_BSLASH;
            f.raw[1]  = CHAR_T;
        end else if (b < 8'h20 || b == BYTE_DEL) begin
            f.raw_cnt = 3'd6;
            f.raw[0]  = BYTE_BSLASH;
            f.raw[1]  = CHAR_U;
            f.raw[2]  = CHAR_ZERO;
            f.raw[3]  = CHAR_ZERO;
            f.raw[4]  = f_hex(b[7:4]);
            f.raw[5]  = f_hex(b[3:0]);
        end else if (b < 8'h80) begin
            f.raw_cnt = 3'd1;
            f.raw[0]  = b;
        end else if (len == 3'd0 || last) begin
            f.fffd = 1'b1;
        end else begin
            f.hold    = 1'b1;
            f.seq_len = len;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: src/jses_front.sv
// ----------------------------------------------------------------------------
// jses_front
// Accepts text bytes, tracks the pending UTF-8 sequence and turns each request
// that is not only held into an output command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jses_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire jses_pkg::t_in  i_req,
    input  wire logic           i_full,
    output logic                o_push,
    output jses_pkg::t_cmd      o_cmd
);
    import jses_pkg::*;

    logic [7:0] r_held [0:2];
    logic [1:0] r_held_cnt, n_held_cnt;
    logic [2:0] r_seq_len, n_seq_len;

    logic       accept;
    logic       held;
    logic       ok;
    logic [2:0] cnt_p1;
    logic       held_we;
    logic [1:0] held_widx;
    t_fresh     fr;
    t_cmd       cmd;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign held    = r_held_cnt != 2'd0;
    assign cnt_p1  = {1'b0, r_held_cnt} + 3'd1;
    assign ok      = (r_held_cnt == 2'd1) ? f_second_ok(r_held[0], i_req.in_byte)
                                          : (i_req.in_byte[7:6] == 2'b10);
    assign fr      = f_fresh(i_req.in_byte, i_req.end_of_text);

    always_comb begin
        cmd          = '0;
        cmd.end_flag = i_req.end_of_text;
        n_held_cnt   = r_held_cnt;
        n_seq_len    = r_seq_len;
        held_we      = 1'b0;
        held_widx    = r_held_cnt;
        if (held && ok) begin
            if (cnt_p1 == r_seq_len) begin
                for (int i = 0; i < 3; i++) begin
                    cmd.raw[i] = (2'(i) < r_held_cnt) ? r_held[i] : i_req.in_byte;
                end
                cmd.raw[3]  = i_req.in_byte;
                cmd.raw_cnt = cnt_p1;
                n_held_cnt  = 2'd0;
                n_seq_len   = 3'd0;
            end else if (i_req.end_of_text) begin
                cmd.fffd_cnt = cnt_p1;
                n_held_cnt   = 2'd0;
                n_seq_len    = 3'd0;
            end else begin
                held_we    = 1'b1;
                n_held_cnt = cnt_p1[1:0];
            end
        end else begin
            cmd.fffd_cnt = (held ? {1'b0, r_held_cnt} : 3'd0) + {2'b00, fr.fffd};
            cmd.raw_cnt  = fr.raw_cnt;
            cmd.raw      = fr.raw;
            if (fr.hold) begin
                held_we    = 1'b1;
                held_widx  = 2'd0;
                n_held_cnt = 2'd1;
                n_seq_len  = fr.seq_len;
            end else begin
                n_held_cnt = 2'd0;
                n_seq_len  = 3'd0;
            end
        end
    end

    assign o_push = accept && (cmd.fffd_cnt != 3'd0 || cmd.raw_cnt != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (accept && held_we) begin
            r_held[held_widx] <= i_req.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_seq_len  <= 3'd0;
        end else if (accept) begin
            r_held_cnt <= n_held_cnt;
            r_seq_len  <= n_seq_len;
        end
    end

`ifndef NO_ASSERTIONS
    a_held_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != 2'd0) |-> ({1'b0, r_held_cnt} < r_seq_len))
        else $error("held count not below sequence length");
    a_empty_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt == 2'd0) |-> (r_seq_len == 3'd0))
        else $error("sequence length set with nothing held");
    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.end_of_text) |-> o_push)
        else $error("final byte produced no output");
`endif

endmodule

`default_nettype wire

FILE: src/jses_queue.sv
// ----------------------------------------------------------------------------
// jses_queue
// Short command queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jses_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jses_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output jses_pkg::t_cmd      o_cmd,
    output logic                o_empty
);
    import jses_pkg::*;

    t_cmd              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: src/jses_back.sv
// ----------------------------------------------------------------------------
// jses_back
// Serializer: expands one queued command into replacement characters and
// literal bytes, one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module jses_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jses_pkg::t_cmd i_cmd,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output jses_pkg::t_out      o_req
);
    import jses_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    logic [2:0] r_fffd_left;
    logic [1:0] r_phase;
    logic [2:0] r_raw_idx;

    logic       fffd_active;
    logic       last;
    logic       accept;
    logic       done;
    logic       take;
    logic [7:0] byte_out;

    assign fffd_active = r_fffd_left != 3'd0;
    assign last = fffd_active
                ? (r_fffd_left == 3'd1 && r_phase == PHASE_2 && r_cmd.raw_cnt == 3'd0)
                : (r_raw_idx == r_cmd.raw_cnt - 3'd1);
    assign accept = r_busy && !i_stall;
    assign done   = accept && last;
    assign take   = (!r_busy || done) && !i_empty;
    assign o_pop  = take;

    always_comb begin
        if (fffd_active) begin
            case (r_phase)
                PHASE_0: byte_out = REPL_0;
                PHASE_1: byte_out = REPL_1;
                default: byte_out = REPL_2;
            endcase
        end else begin
            byte_out = r_cmd.raw[r_raw_idx];
        end
    end

    assign o_valid          = r_busy;
    assign o_req.out_byte   = byte_out;
    assign o_req.run_last   = last;
    assign o_req.text_done  = last && r_cmd.end_flag;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fffd_left <= 3'd0;
            r_phase     <= PHASE_0;
            r_raw_idx   <= 3'd0;
        end else if (take) begin
            r_busy      <= 1'b1;
            r_fffd_left <= i_cmd.fffd_cnt;
            r_phase     <= PHASE_0;
            r_raw_idx   <= 3'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            if (fffd_active) begin
                if (r_phase == PHASE_2) begin
                    r_phase     <= PHASE_0;
                    r_fffd_left <= r_fffd_left - 3'd1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end else begin
                r_raw_idx <= r_raw_idx + 3'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_phase != 2'd3))
        else $error("replacement phase out of range");
    a_raw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !fffd_active) |-> (r_raw_idx < r_cmd.raw_cnt))
        else $error("raw byte index past command length");
    a_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_fffd_left != 3'd0 || r_cmd.raw_cnt != 3'd0))
        else $error("empty command loaded");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_stall) |=> (r_busy && $stable(byte_out)))
        else $error("stalled output byte changed");
`endif

endmodule

`default_nettype wire

FILE: src/json_string_escape_utf8_sanitize_core.sv
// ----------------------------------------------------------------------------
// json_string_escape_utf8_sanitize_core
// JSON string escaper with UTF-8 validation: escapes quotes, backslashes and
// control bytes, holds multi-byte sequences until complete, and replaces
// malformed input with U+FFFD.
// ----------------------------------------------------------------------------
//  Channel   Direction  Valid        Stall        Request
//  input     in         i_in_valid   o_in_stall   i_in_req  (in_byte, end_of_text)
//  output    out        o_out_valid  i_out_stall  o_out_req (out_byte, run_last, text_done)
//
//  The classifier takes one text byte per cycle while the four-entry command
//  queue has room. The serializer sends one output byte per cycle while the
//  output is not stalled; a queued command expands to 1 to 15 output bytes.
//  The first output byte of a request is registered in the command queue and
//  then in the serializer before it is valid.
//  Reset is synchronous and clears the pending sequence, queue and serializer.
//  Output stall fills the queue and then raises input stall.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escape_utf8_sanitize_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire jses_pkg::t_in  i_in_req,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output jses_pkg::t_out      o_out_req
);
    import jses_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    jses_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (i_in_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    jses_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    jses_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_req   (o_out_req)
    );

endmodule

`default_nettype wire

FILE: tb/tb_json_string_escape_utf8_sanitize_core.sv
// ----------------------------------------------------------------------------
// tb_json_string_escape_utf8_sanitize_core
// Self-checking testbench for the JSON string escaper with UTF-8 validation.
// Directed tests cover every escape form, the E0 and F4 second byte limits,
// stray continuations, an invalid lead and truncated sequences. A long random
// text of mostly well-formed UTF-8 follows. Each accepted request is run
// through a local model, and every output byte is compared with the oldest
// predicted byte while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_json_string_escape_utf8_sanitize_core;

    import jses_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 360;
    localparam int DRAIN_CYCLES   = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] SEC_E0_LO  = 8'hA0;
    localparam logic [7:0] SEC_F0_LO  = 8'h90;
    localparam logic [7:0] SEC_ED_HI  = 8'h9F;
    localparam logic [7:0] SEC_F4_HI  = 8'h8F;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in_req    = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_req;

    logic [7:0] pend_bytes [3];
    logic [1:0] pend_cnt = 2'd0;
    logic [2:0] pend_len = 3'd0;
    logic [7:0] step_bytes [$];
    t_out       escaped_q [$];

    int   fail_count    = 0;
    int   idle_cycles   = 0;
    int   requests_sent = 0;
    int   stall_left    = 0;
    logic no_idle       = 1'b0;

    json_string_escape_utf8_sanitize_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHAR_ZERO + {4'h0, nib};
        end
        return CHAR_A + {4'h0, nib} - 8'd10;
    endfunction

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            return 3'd2;
        end else if (b >= LEAD_E0 && b <= LEAD3_HI) begin
            return 3'd3;
        end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
            return 3'd4;
        end
        return 3'd0;
    endfunction

    function automatic logic [7:0] second_low(input logic [7:0] lead);
        case (lead)
            LEAD_E0: return SEC_E0_LO;
            LEAD_F0: return SEC_F0_LO;
            default: return CONT_LO;
        endcase
    endfunction

    function automatic logic [7:0] second_high(input logic [7:0] lead);
        case (lead)
            LEAD_ED: return SEC_ED_HI;
            LEAD_F4: return SEC_F4_HI;
            default: return CONT_HI;
        endcase
    endfunction

    task automatic push_replacement();
        step_bytes.push_back(REPL_0);
        step_bytes.push_back(REPL_1);
        step_bytes.push_back(REPL_2);
    endtask

    task automatic escape_fresh(input logic [7:0] b, input logic eot);
        logic [2:0] len;
        len = seq_length(b);
        if (b == BYTE_QUOTE || b == BYTE_BSLASH) begin
            step_bytes.push_back(BYTE_BSLASH);
            step_bytes.push_back(b);
        end else if (b == BYTE_LF) begin
            step_bytes.push_back(BYTE_BSLASH);
            step_bytes.push_back(CHAR_N);
        end else if (b == BYTE_CR) begin
            step_bytes.push_back(BYTE_BSLASH);
            step_bytes.push_back(CHAR_R);
        end else if (b == BYTE_TAB) begin
            step_bytes.push_back(BYTE_BSLASH);
            step_bytes.push_back(CHAR_T);
        end else if (b < CTRL_LIMIT || b == BYTE_DEL) begin
            step_bytes.push_back(BYTE_BSLASH);
            step_bytes.push_back(CHAR_U);
            step_bytes.push_back(CHAR_ZERO);
            step_bytes.push_back(CHAR_ZERO);
            step_bytes.push_back(hex_char(b[7:4]));
            step_bytes.push_back(hex_char(b[3:0]));
        end else if (b < CONT_LO) begin
            step_bytes.push_back(b);
        end else if (len == 3'd0 || eot) begin
            push_replacement();
        end else begin
            pend_bytes[0] = b;
            pend_cnt      = 2'd1;
            pend_len      = len;
        end
    endtask

    task automatic escape_request(input t_in req);
        logic [7:0] b;
        logic       eot;
        logic       cont_ok;
        int         k;
        t_out       res;
        b   = req.in_byte;
        eot = req.end_of_text;
        step_bytes.delete();
        if (pend_cnt != 2'd0 && {1'b0, pend_cnt} < pend_len) begin
            if (pend_cnt == 2'd1) begin
                cont_ok = (b >= second_low(pend_bytes[0]) && b <= second_high(pend_bytes[0]));
            end else begin
                cont_ok = (b[7:6] == 2'b10);
            end
            if (cont_ok && {1'b0, pend_cnt} + 3'd1 == pend_len) begin
                for (k = 0; k < pend_cnt; k++) begin
                    step_bytes.push_back(pend_bytes[k]);
                end
                step_bytes.push_back(b);
                pend_cnt = 2'd0;
                pend_len = 3'd0;
            end else if (cont_ok && eot) begin
                for (k = 0; k <= pend_cnt; k++) begin
                    push_replacement();
                end
                pend_cnt = 2'd0;
                pend_len = 3'd0;
            end else if (cont_ok) begin
                pend_bytes[pend_cnt] = b;
                pend_cnt             = pend_cnt + 2'd1;
            end else begin
                for (k = 0; k < pend_cnt; k++) begin
                    push_replacement();
                end
                pend_cnt = 2'd0;
                pend_len = 3'd0;
                escape_fresh(b, eot);
            end
        end else begin
            pend_cnt = 2'd0;
            pend_len = 3'd0;
            escape_fresh(b, eot);
        end
        for (k = 0; k < step_bytes.size(); k++) begin
            res.out_byte  = step_bytes[k];
            res.run_last  = (k == step_bytes.size() - 1);
            res.text_done = (k == step_bytes.size() - 1) && eot;
            escaped_q.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        idle_cycles++;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            escape_request(i_in_req);
            idle_cycles = 0;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            idle_cycles = 0;
            if (escaped_q.size() == 0) begin
                report_mismatch("output byte with no request pending", o_out_req.out_byte, 0);
            end else begin
                want = escaped_q.pop_front();
                if (o_out_req.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_out_req.out_byte, want.out_byte);
                end
                if (o_out_req.run_last !== want.run_last) begin
                    report_mismatch("run_last", o_out_req.run_last, want.run_last);
                end
                if (o_out_req.text_done !== want.text_done) begin
                    report_mismatch("text_done", o_out_req.text_done, want.text_done);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
                    i_out_stall <= 1'b0;
                    stall_left = $urandom_range(0, 4);
                end
                19: begin
                    i_out_stall <= 1'b1;
                    stall_left = $urandom_range(10, 40);
                end
                default: begin
                    i_out_stall <= 1'b1;
                    stall_left = $urandom_range(0, 2);
                end
            endcase
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("FAIL");
        $finish;
    end

    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic [7:0] b, input logic eot);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= '{in_byte: b, end_of_text: eot};
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        requests_sent++;
    endtask

    function automatic logic random_end();
        return ($urandom_range(0, 19) == 0);
    endfunction

    task automatic send_utf8(input logic broken);
        logic [7:0] seq [4];
        int         len;
        int         cut;
        int         k;
        len = $urandom_range(2, 4);
        case (len)
            2: seq[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
            3: seq[0] = 8'($urandom_range(LEAD_E0, LEAD3_HI));
            default: seq[0] = 8'($urandom_range(LEAD_F0, LEAD_F4));
        endcase
        seq[1] = 8'($urandom_range(second_low(seq[0]), second_high(seq[0])));
        seq[2] = 8'($urandom_range(CONT_LO, CONT_HI));
        seq[3] = 8'($urandom_range(CONT_LO, CONT_HI));
        cut = len - 1;
        if (broken) begin
            cut      = $urandom_range(1, len - 1);
            seq[cut] = 8'($urandom_range(0, 255));
        end
        for (k = 0; k <= cut; k++) begin
            send_request(seq[k], random_end());
        end
    endtask

    task automatic test_escapes();
        send_request(BYTE_QUOTE, 1'b0);
        send_request(BYTE_BSLASH, 1'b0);
        send_request(BYTE_LF, 1'b0);
        send_request(BYTE_CR, 1'b0);
        send_request(BYTE_TAB, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(BYTE_DEL, 1'b0);
        send_request(CTRL_LIMIT, 1'b1);
    endtask

    task automatic test_multibyte();
        send_request(LEAD_E0, 1'b0);
        send_request(SEC_E0_LO, 1'b0);
        send_request(CONT_LO, 1'b0);
        send_request(LEAD_F4, 1'b0);
        send_request(SEC_F4_HI, 1'b0);
        send_request(CONT_HI, 1'b0);
        send_request(CONT_HI, 1'b1);
    endtask

    task automatic test_malformed();
        send_request(CONT_LO, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(LEAD2_LO, 1'b0);
        send_request(8'h41, 1'b0);
        send_request(LEAD_E0, 1'b1);
        send_request(8'hE1, 1'b0);
        send_request(CONT_LO, 1'b1);
    endtask

    task automatic test_random_text();
        int first;
        int next_mode;
        int kind;
        first     = requests_sent;
        next_mode = first;
        while (requests_sent - first < RANDOM_ITEMS) begin
            if (requests_sent >= next_mode) begin
                no_idle   = ($urandom_range(0, 3) == 0);
                next_mode = requests_sent + $urandom_range(30, 80);
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                send_request(8'($urandom_range(0, BYTE_DEL)), random_end());
            end else if (kind < 75) begin
                send_utf8(1'b0);
            end else if (kind < 90) begin
                send_utf8(1'b1);
            end else begin
                send_request(8'($urandom_range(0, 255)), random_end());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_escapes();
        test_multibyte();
        test_malformed();
        test_random_text();
        i_in_valid <= 1'b0;
        no_idle = 1'b1;
        while (escaped_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/jses_pkg.sv
src/jses_front.sv
src/jses_queue.sv
src/jses_back.sv
src/json_string_escape_utf8_sanitize_core.sv
tb/tb_json_string_escape_utf8_sanitize_core.sv
